// ===== src/graphics_cell_pixel_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graphics cell pixel decoder
// Shared wrappers for concurrent assertions in the checker.
// ----------------------------------------------------------------------------
`ifndef GRAPHICS_CELL_PIXEL_DECODER_CORE_ASSERT_SVH
`define GRAPHICS_CELL_PIXEL_DECODER_CORE_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define GCPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gcpd assertion failed");

// Assertion that also holds during reset.
`define GCPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gcpd assertion failed");

`endif

// ===== src/gcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Graphics cell pixel decoder package
// Request and result types, configuration state, mode and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gcpd_pkg;

    localparam int unsigned NUM_PIXELS = 8;
    localparam int unsigned NUM_PAIRS  = 4;

    // Display mode codes as they appear on the result.
    typedef enum logic [2:0] {
        MODE_BLANK      = 3'd0,
        MODE_STD_TEXT   = 3'd1,
        MODE_MC_TEXT    = 3'd2,
        MODE_EXT_TEXT   = 3'd3,
        MODE_STD_BITMAP = 3'd4,
        MODE_MC_BITMAP  = 3'd5,
        MODE_INVALID    = 3'd6
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_DISPLAY_ENABLE = 3'd0,
        REG_EXT_COLOUR     = 3'd1,
        REG_BITMAP         = 3'd2,
        REG_MULTICOLOUR    = 3'd3,
        REG_BACKGROUND_0   = 3'd4,
        REG_BACKGROUND_1   = 3'd5,
        REG_BACKGROUND_2   = 3'd6,
        REG_BACKGROUND_3   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] screen_code;
        logic [3:0] cell_colour;
        logic [7:0] pattern_byte;
    } t_cell_in;

    typedef struct packed {
        logic [3:0] pixel_0;
        logic [3:0] pixel_1;
        logic [3:0] pixel_2;
        logic [3:0] pixel_3;
        logic [3:0] pixel_4;
        logic [3:0] pixel_5;
        logic [3:0] pixel_6;
        logic [3:0] pixel_7;
        logic [7:0] foreground_mask;
        logic [2:0] mode_code;
    } t_cell_out;

    // Decoded configuration handed from the register file to the datapath.
    typedef struct packed {
        t_mode      mode;
        logic [3:0] background_0;
        logic [3:0] background_1;
        logic [3:0] background_2;
        logic [3:0] background_3;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/gcpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the mode bits and background colours and decodes the display mode.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_cfg_regs
    import gcpd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    output t_cfg            o_cfg
);

    logic       r_display_enable;
    logic       r_ext_colour;
    logic       r_bitmap;
    logic       r_multicolour;
    logic [3:0] r_background_0;
    logic [3:0] r_background_1;
    logic [3:0] r_background_2;
    logic [3:0] r_background_3;
    t_mode      n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b0;
            r_ext_colour     <= 1'b0;
            r_bitmap         <= 1'b0;
            r_multicolour    <= 1'b0;
            r_background_0   <= 4'd0;
            r_background_1   <= 4'd0;
            r_background_2   <= 4'd0;
            r_background_3   <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_DISPLAY_ENABLE: r_display_enable <= i_cfg_data[0];
                REG_EXT_COLOUR:     r_ext_colour     <= i_cfg_data[0];
                REG_BITMAP:         r_bitmap         <= i_cfg_data[0];
                REG_MULTICOLOUR:    r_multicolour    <= i_cfg_data[0];
                REG_BACKGROUND_0:   r_background_0   <= i_cfg_data;
                REG_BACKGROUND_1:   r_background_1   <= i_cfg_data;
                REG_BACKGROUND_2:   r_background_2   <= i_cfg_data;
                REG_BACKGROUND_3:   r_background_3   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Extended colour together with bitmap or multicolour is not a valid mode.
    always_comb begin
        if (!r_display_enable) begin
            n_mode = MODE_BLANK;
        end else if (!r_ext_colour && !r_bitmap) begin
            n_mode = r_multicolour ? MODE_MC_TEXT : MODE_STD_TEXT;
        end else if (r_ext_colour && !r_bitmap && !r_multicolour) begin
            n_mode = MODE_EXT_TEXT;
        end else if (!r_ext_colour && r_bitmap) begin
            n_mode = r_multicolour ? MODE_MC_BITMAP : MODE_STD_BITMAP;
        end else begin
            n_mode = MODE_INVALID;
        end
    end

    assign o_cfg.mode         = n_mode;
    assign o_cfg.background_0 = r_background_0;
    assign o_cfg.background_1 = r_background_1;
    assign o_cfg.background_2 = r_background_2;
    assign o_cfg.background_3 = r_background_3;

endmodule

`default_nettype wire

// ===== src/gcpd_decode.sv =====
// ----------------------------------------------------------------------------
// Cell decode datapath
// Input register, pixel and mask selection, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_decode
    import gcpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_cell_in i_cell,
    input  wire t_cfg     i_cfg,
    output logic          o_valid,
    output t_cell_out     o_result
);

    logic       r_in_valid;
    t_cell_in   r_in;
    logic       r_out_valid;
    t_cell_out  r_out;

    logic       n_multi;
    logic [7:0] n_bits;
    logic [3:0] n_fg;
    logic [3:0] n_bg;
    logic [3:0] n_pal [NUM_PAIRS];
    logic [3:0] n_px  [NUM_PIXELS];
    logic [7:0] n_mask;
    logic [1:0] n_pair;
    t_cell_out  n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in <= i_cell;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    // Pick hires or pair decoding and the colours it draws from.
    always_comb begin
        n_multi  = 1'b0;
        n_bits   = r_in.pattern_byte;
        n_fg     = r_in.cell_colour;
        n_bg     = i_cfg.background_0;
        n_pal[0] = i_cfg.background_0;
        n_pal[1] = i_cfg.background_1;
        n_pal[2] = i_cfg.background_2;
        n_pal[3] = {1'b0, r_in.cell_colour[2:0]};
        unique case (i_cfg.mode)
            MODE_STD_TEXT: begin
            end
            MODE_MC_TEXT: begin
                // Colour bit 3 clear falls back to hires with a 3-bit colour.
                n_multi = r_in.cell_colour[3];
                n_fg    = {1'b0, r_in.cell_colour[2:0]};
            end
            MODE_EXT_TEXT: begin
                case (r_in.screen_code[7:6])
                    2'd0:    n_bg = i_cfg.background_0;
                    2'd1:    n_bg = i_cfg.background_1;
                    2'd2:    n_bg = i_cfg.background_2;
                    default: n_bg = i_cfg.background_3;
                endcase
            end
            MODE_STD_BITMAP: begin
                n_fg = r_in.screen_code[7:4];
                n_bg = r_in.screen_code[3:0];
            end
            MODE_MC_BITMAP: begin
                n_multi  = 1'b1;
                n_pal[1] = r_in.screen_code[7:4];
                n_pal[2] = r_in.screen_code[3:0];
                n_pal[3] = r_in.cell_colour;
            end
            MODE_BLANK, MODE_INVALID: begin
                n_bits = 8'h00;
            end
            default: begin
                n_bits = 8'h00;
            end
        endcase
    end

    // Per-pixel selection; pairs share one 2-bit code in multicolour.
    always_comb begin
        n_mask = n_bits;
        n_pair = 2'd0;
        for (int i = 0; i < NUM_PIXELS; i++) begin
            n_pair = {n_bits[7 - 2 * (i / 2)], n_bits[6 - 2 * (i / 2)]};
            if (n_multi) begin
                n_px[i]       = n_pal[n_pair];
                n_mask[7 - i] = n_pair[1];
            end else begin
                n_px[i] = n_bits[7 - i] ? n_fg : n_bg;
            end
        end
    end

    always_comb begin
        n_out.pixel_0         = n_px[0];
        n_out.pixel_1         = n_px[1];
        n_out.pixel_2         = n_px[2];
        n_out.pixel_3         = n_px[3];
        n_out.pixel_4         = n_px[4];
        n_out.pixel_5         = n_px[5];
        n_out.pixel_6         = n_px[6];
        n_out.pixel_7         = n_px[7];
        n_out.foreground_mask = n_mask;
        n_out.mode_code       = i_cfg.mode;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== src/graphics_cell_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Graphics cell pixel decoder core
// Turns one scanline of one character cell into eight pixel colours.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   --------  --------------------------  ---------------------------------
//   request   i_start, o_busy             i_cell (screen, colour, pattern)
//   result    o_result_valid (strobe)     o_result (pixels, mask, mode)
//   config    i_cfg_valid, o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request is taken on every clock edge where i_start is high; o_busy
// stays low, so one cell per clock is sustained.
// Each result strobe comes from the result register: the clock edge that takes
// a request loads the input register, and the result register is loaded from it
// through the pixel selection.
// Reset is synchronous and active low; it clears the pipeline valid bits and
// all configuration registers. The result strobe lasts one cycle and the
// receiver cannot stall it, so nothing in the design ever waits.
//
`default_nettype none

module graphics_cell_pixel_decoder_core
    import gcpd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_cell_in   i_cell,
    output logic            o_result_valid,
    output t_cell_out       o_result,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data
);

    t_cfg cfg;
    logic req_accept;

    // The datapath is fully pipelined, so requests are never refused.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_accept  = i_start && !o_busy;

    // Configuration registers. The user writes them only with no request in
    // flight (not enforced by the block); the datapath reads them directly.
    gcpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Two-stage datapath: request register, then the selection logic into the
    // result register that drives the output ports.
    gcpd_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (req_accept),
        .i_cell   (i_cell),
        .i_cfg    (cfg),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== src/gcpd_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the graphics cell pixel decoder
// Watches request and result timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graphics_cell_pixel_decoder_core_assert.svh"

module gcpd_checker
    import gcpd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_result_valid,
    input wire t_cell_out  o_result
);

    logic blank_like;
    logic mc_bitmap;

    assign blank_like = (o_result.mode_code == MODE_BLANK)
                     || (o_result.mode_code == MODE_INVALID);
    assign mc_bitmap  = o_result.mode_code == MODE_MC_BITMAP;

    // Every accepted request yields a result through the input and result registers.
    `GCPD_ASSERT(a_req_to_result, i_clk, i_rst_n, (i_start && !o_busy) ##1 i_rst_n |=> o_result_valid)

    // No result appears without a matching earlier accepted request.
    `GCPD_ASSERT(a_no_spurious_result, i_clk, i_rst_n, o_result_valid |-> $past(i_start && !o_busy, 2))

    // Blank and invalid modes show no foreground and a flat background.
    `GCPD_ASSERT(a_blank_flat, i_clk, i_rst_n, (o_result_valid && blank_like) |-> (o_result.foreground_mask == 8'h00 && o_result.pixel_0 == o_result.pixel_7))

    // Multicolour bitmap pixels come in equal pairs.
    `GCPD_ASSERT(a_mc_pairs, i_clk, i_rst_n, (o_result_valid && mc_bitmap) |-> (o_result.pixel_0 == o_result.pixel_1 && o_result.pixel_6 == o_result.pixel_7 && o_result.foreground_mask[7] == o_result.foreground_mask[6]))

    // The block takes a request in every cycle.
    `GCPD_ASSERT_ALWAYS(a_never_busy, i_clk, !o_busy)

endmodule

bind graphics_cell_pixel_decoder_core gcpd_checker u_gcpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

// ===== sim/graphics_cell_pixel_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// Graphics cell pixel decoder testbench
// Sends cell requests under several display setups and checks every pixel,
// mask and mode result against a predictor that runs alongside the block.
// ----------------------------------------------------------------------------

module graphics_cell_pixel_decoder_core_tb;

    import gcpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_cell_in   cell_req;
    logic       result_valid;
    t_cell_out  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [3:0] cfg_data;

    graphics_cell_pixel_decoder_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cell         (cell_req),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Shadow copy of the display registers, updated on every accepted write.
    logic       disp_en;
    logic       ext_colour;
    logic       bitmap_sel;
    logic       multicolour_sel;
    logic [3:0] bg_colour [4];

    t_cell_out  pending_pixels [$];
    int         sender_idle_pct;
    int         error_count;
    int         request_count;
    int         result_count;
    int         cycle_count;
    int         mode_seen [7];

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_mode current_mode();
        if (!disp_en)
            return MODE_BLANK;
        if (!ext_colour && !bitmap_sel)
            return multicolour_sel ? MODE_MC_TEXT : MODE_STD_TEXT;
        if (ext_colour && !bitmap_sel && !multicolour_sel)
            return MODE_EXT_TEXT;
        if (!ext_colour && bitmap_sel)
            return multicolour_sel ? MODE_MC_BITMAP : MODE_STD_BITMAP;
        return MODE_INVALID;
    endfunction

    // Works out the eight pixel colours, the foreground mask and the mode
    // for one cell under the current register settings.
    function automatic t_cell_out decode_cell_pixels(t_cell_in c);
        t_mode      m;
        logic [3:0] px [8];
        logic [3:0] pal [4];
        logic [7:0] fg;
        logic [3:0] on_colour;
        logic [3:0] off_colour;
        logic [1:0] pair;
        bit         two_bit;
        t_cell_out  r;

        m          = current_mode();
        fg         = c.pattern_byte;
        on_colour  = c.cell_colour;
        off_colour = bg_colour[0];
        two_bit    = 1'b0;
        pal        = '{4'h0, 4'h0, 4'h0, 4'h0};
        case (m)
            MODE_STD_TEXT: begin
            end
            MODE_MC_TEXT: begin
                // Colour bit 3 clear falls back to single-bit pixels.
                if (c.cell_colour[3]) begin
                    two_bit = 1'b1;
                    pal = '{bg_colour[0], bg_colour[1], bg_colour[2],
                            {1'b0, c.cell_colour[2:0]}};
                end else begin
                    on_colour = {1'b0, c.cell_colour[2:0]};
                end
            end
            MODE_EXT_TEXT: begin
                off_colour = bg_colour[c.screen_code[7:6]];
            end
            MODE_STD_BITMAP: begin
                on_colour  = c.screen_code[7:4];
                off_colour = c.screen_code[3:0];
            end
            MODE_MC_BITMAP: begin
                two_bit = 1'b1;
                pal = '{bg_colour[0], c.screen_code[7:4], c.screen_code[3:0],
                        c.cell_colour};
            end
            default: begin
                // Blank and invalid show background 0 everywhere.
                fg = 8'h00;
            end
        endcase

        for (int i = 0; i < 8; i++) begin
            if (two_bit) begin
                pair      = c.pattern_byte[7 - 2 * (i / 2) -: 2];
                px[i]     = pal[pair];
                fg[7 - i] = pair[1];
            end else begin
                px[i] = fg[7 - i] ? on_colour : off_colour;
            end
        end

        r = '{px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7], fg, m};
        return r;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [3:0] data);
        case (t_cfg_idx'(idx))
            REG_DISPLAY_ENABLE: disp_en         = data[0];
            REG_EXT_COLOUR:     ext_colour      = data[0];
            REG_BITMAP:         bitmap_sel      = data[0];
            REG_MULTICOLOUR:    multicolour_sel = data[0];
            REG_BACKGROUND_0:   bg_colour[0]    = data;
            REG_BACKGROUND_1:   bg_colour[1]    = data;
            REG_BACKGROUND_2:   bg_colour[2]    = data;
            REG_BACKGROUND_3:   bg_colour[3]    = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, name, want, got);
        end
    endtask

    // All sampling happens at the rising edge; inputs were settled at the
    // previous falling edge, so nothing here races the block.
    always @(posedge clk) begin : monitor
        t_cell_out want;
        if (rst_n) begin
            if (result_valid) begin
                if (pending_pixels.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with no request waiting, got %h",
                                 $time, result);
                end else begin
                    want = pending_pixels.pop_front();
                    result_count++;
                    if (want.mode_code < 7)
                        mode_seen[want.mode_code]++;
                    check_field("pixel_0", want.pixel_0, result.pixel_0);
                    check_field("pixel_1", want.pixel_1, result.pixel_1);
                    check_field("pixel_2", want.pixel_2, result.pixel_2);
                    check_field("pixel_3", want.pixel_3, result.pixel_3);
                    check_field("pixel_4", want.pixel_4, result.pixel_4);
                    check_field("pixel_5", want.pixel_5, result.pixel_5);
                    check_field("pixel_6", want.pixel_6, result.pixel_6);
                    check_field("pixel_7", want.pixel_7, result.pixel_7);
                    check_field("foreground_mask", want.foreground_mask,
                                result.foreground_mask);
                    check_field("mode_code", want.mode_code, result.mode_code);
                end
            end
            if (start && !busy) begin
                pending_pixels.push_back(decode_cell_pixels(cell_req));
                request_count++;
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    task automatic send_cell(logic [7:0] screen, logic [3:0] colour,
                             logic [7:0] pattern);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        cell_req <= '{screen, colour, pattern};
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // Stops sending and waits until every request has produced its result.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge clk); while (pending_pixels.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Writes the whole register set once the block is idle. The unused
    // upper data bits of the single-bit registers carry random junk.
    task automatic load_display_setup(bit en, bit ecm, bit bmm, bit mcm,
                                      logic [3:0] b0, logic [3:0] b1,
                                      logic [3:0] b2, logic [3:0] b3);
        drain_results();
        write_register(REG_DISPLAY_ENABLE, {3'($urandom), en});
        write_register(REG_EXT_COLOUR,     {3'($urandom), ecm});
        write_register(REG_BITMAP,         {3'($urandom), bmm});
        write_register(REG_MULTICOLOUR,    {3'($urandom), mcm});
        write_register(REG_BACKGROUND_0,   b0);
        write_register(REG_BACKGROUND_1,   b1);
        write_register(REG_BACKGROUND_2,   b2);
        write_register(REG_BACKGROUND_3,   b3);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers come out of reset cleared, which is blank mode.
    task automatic test_blank_after_reset();
        send_cell(8'h00, 4'h0, 8'h00);
        send_cell(8'hFF, 4'hF, 8'hFF);
    endtask

    task automatic test_standard_text();
        load_display_setup(1, 0, 0, 0, 4'hF, 4'h1, 4'h2, 4'h3);
        send_cell(8'h00, 4'hF, 8'hAA);
        send_cell(8'hFF, 4'h0, 8'h55);
    endtask

    // Covers the hires fallback when colour bit 3 is clear and all four
    // pair codes in true multicolour.
    task automatic test_multicolour_text();
        load_display_setup(1, 0, 0, 1, 4'h0, 4'h5, 4'hA, 4'hF);
        send_cell(8'h00, 4'h7, 8'hE4);
        send_cell(8'h00, 4'h8, 8'hE4);
        send_cell(8'hFF, 4'hF, 8'h1B);
    endtask

    // The top two screen bits pick each of the four backgrounds.
    task automatic test_extended_text();
        load_display_setup(1, 1, 0, 0, 4'h1, 4'h2, 4'h3, 4'h4);
        send_cell(8'h00, 4'h9, 8'hA5);
        send_cell(8'h7F, 4'h9, 8'hA5);
        send_cell(8'h80, 4'h9, 8'hA5);
        send_cell(8'hC0, 4'h9, 8'hA5);
    endtask

    task automatic test_standard_bitmap();
        load_display_setup(1, 0, 1, 0, 4'h6, 4'h0, 4'h0, 4'h0);
        send_cell(8'hA5, 4'h3, 8'hF0);
        send_cell(8'h0F, 4'hC, 8'h0F);
    endtask

    task automatic test_multicolour_bitmap();
        load_display_setup(1, 0, 1, 1, 4'h9, 4'h0, 4'h0, 4'h0);
        send_cell(8'h12, 4'hF, 8'hE4);
        send_cell(8'hFE, 4'h0, 8'h1B);
    endtask

    // Illegal bit combinations, and blank with every other bit set.
    task automatic test_invalid_modes();
        load_display_setup(1, 1, 1, 0, 4'h7, 4'h1, 4'h2, 4'h3);
        send_cell(8'hFF, 4'hF, 8'hFF);
        load_display_setup(1, 1, 0, 1, 4'hB, 4'h1, 4'h2, 4'h3);
        send_cell(8'hC3, 4'h8, 8'hE4);
        load_display_setup(1, 1, 1, 1, 4'h2, 4'hF, 4'hF, 4'hF);
        send_cell(8'h5A, 4'h1, 8'h81);
        load_display_setup(0, 1, 1, 1, 4'hD, 4'h1, 4'h2, 4'h3);
        send_cell(8'hFF, 4'hF, 8'hFF);
    endtask

    // Random cells in blocks of 100 with a fresh setup per block. The first
    // two blocks use all-zero and all-ones backgrounds; the sender idle rate
    // rotates through none, heavy and light. Extended colour is kept rarer
    // so that most blocks land on a legal mode.
    task automatic test_random_cells();
        int idle_plan [3];
        bit en;
        bit ecm;
        logic [3:0] b [4];
        idle_plan = '{0, 78, 7};
        for (int blk = 0; blk < 13; blk++) begin
            en  = ($urandom_range(0, 7) != 0);
            ecm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 4; k++)
                b[k] = (blk == 0) ? 4'h0 : (blk == 1) ? 4'hF : 4'($urandom);
            load_display_setup(en, ecm, 1'($urandom), 1'($urandom),
                               b[0], b[1], b[2], b[3]);
            sender_idle_pct = idle_plan[blk % 3];
            for (int n = 0; n < 100; n++) begin
                // Once, hold off mid-block until the block has gone quiet.
                if (blk == 4 && n == 50)
                    drain_results();
                send_cell(8'($urandom), 4'($urandom), 8'($urandom));
            end
        end
        sender_idle_pct = 0;
    endtask

    task automatic finish_run();
        start <= 1'b0;
        for (int k = 0; k < 50 && pending_pixels.size() != 0; k++)
            @(negedge clk);
        if (pending_pixels.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time,
                     pending_pixels.size());
        end
        repeat (4) @(negedge clk);
        $display("Covered %0d requests and %0d checked results under random and edge setups.",
                 request_count, result_count);
        $display("Per mode: blank %0d, std text %0d, mc text %0d, ext text %0d, "
                 , mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
                 "std bitmap %0d, mc bitmap %0d, invalid %0d",
                 mode_seen[4], mode_seen[5], mode_seen[6]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    endtask

    initial begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cell_req        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        disp_en         = 1'b0;
        ext_colour      = 1'b0;
        bitmap_sel      = 1'b0;
        multicolour_sel = 1'b0;
        bg_colour       = '{4'h0, 4'h0, 4'h0, 4'h0};
        sender_idle_pct = 0;
        error_count     = 0;
        request_count   = 0;
        result_count    = 0;
        cycle_count     = 0;
        mode_seen       = '{0, 0, 0, 0, 0, 0, 0};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_blank_after_reset();
        test_standard_text();
        test_multicolour_text();
        test_extended_text();
        test_standard_bitmap();
        test_multicolour_bitmap();
        test_invalid_modes();
        test_random_cells();
        finish_run();
    end

endmodule

// ===== sim.f =====
+incdir+src
src/gcpd_pkg.sv
src/gcpd_cfg_regs.sv
src/gcpd_decode.sv
src/graphics_cell_pixel_decoder_core.sv
src/gcpd_checker.sv
sim/graphics_cell_pixel_decoder_core_tb.sv
